FILE: sv/string_literal_unescape_top_macros.svh
// Assertion macros shared by the string unescape block.
`ifndef STRING_LITERAL_UNESCAPE_TOP_MACROS_SVH
`define STRING_LITERAL_UNESCAPE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define SLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/slu_pkg.sv
package slu_pkg;

  // Decoder mode
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_DROP   = 3'd4
  } mode_t;

  // Result kinds
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_END    = 3'd1;
  localparam logic [2:0] KIND_OPEN   = 3'd2;
  localparam logic [2:0] KIND_BADESC = 3'd3;
  localparam logic [2:0] KIND_BADHEX = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] HEX_MAX      = 8'h7F;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_closing;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_out;
    logic [7:0] detail_first;
    logic [7:0] detail_second;
    logic [1:0] detail_count;
    logic       run_last;
  } res_t;

  // Results of one item, handed from the decoder to the output buffer
  typedef struct packed {
    res_t       first;
    res_t       second;
    logic [1:0] count;
  } dec_out_t;

  function automatic res_t res_make(logic [2:0] kind, logic [7:0] b,
                                    logic [7:0] d1, logic [7:0] d2,
                                    logic [1:0] cnt);
    res_t r;
    r.kind          = kind;
    r.byte_out      = b;
    r.detail_first  = d1;
    r.detail_second = d2;
    r.detail_count  = cnt;
    r.run_last      = 1'b0;
    return r;
  endfunction

  // Known single-character escapes
  function automatic logic esc_known(logic [7:0] ch);
    return (ch == CH_N) || (ch == CH_T) || (ch == CH_R) || (ch == CH_ZERO) ||
           (ch == CH_QUOTE) || (ch == CH_BACKSLASH);
  endfunction

  function automatic logic [7:0] esc_byte(logic [7:0] ch);
    logic [7:0] v;
    case (ch)
      CH_N:         v = 8'h0A;
      CH_T:         v = 8'h09;
      CH_R:         v = 8'h0D;
      CH_QUOTE:     v = 8'h22;
      CH_BACKSLASH: v = 8'h5C;
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic hex_ok(logic [7:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
           (ch >= 8'h41 && ch <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(logic [7:0] ch);
    logic [7:0] v;
    if (ch >= 8'h30 && ch <= 8'h39) v = ch - 8'h30;
    else if (ch >= 8'h61 && ch <= 8'h66) v = ch - 8'h57;
    else if (ch >= 8'h41 && ch <= 8'h46) v = ch - 8'h37;
    else v = 8'h00;
    return v[3:0];
  endfunction

endpackage

FILE: sv/slu_decode.sv
module slu_decode (
  input  logic            clk,
  input  logic            rst,
  input  slu_pkg::item_t  item,
  input  logic            fire,
  output slu_pkg::dec_out_t dec
);
  import slu_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic [7:0] ch;
  logic       closing;
  logic [7:0] hex_pair;
  logic       hex_good;

  assign ch       = item.char_in;
  assign closing  = item.is_closing;
  assign hex_pair = {hex_nib(held), hex_nib(ch)};
  assign hex_good = hex_ok(held) && hex_ok(ch) && (hex_pair <= HEX_MAX);

  // Next mode and held digit
  always_comb begin
    mode_next = mode;
    held_next = held;
    unique case (mode)
      MODE_ESC: begin
        if (esc_known(ch)) mode_next = MODE_NORMAL;
        else if (ch == CH_X && !closing) mode_next = MODE_HEX0;
        else mode_next = closing ? MODE_NORMAL : MODE_DROP;
      end
      MODE_HEX0: begin
        if (closing) begin
          mode_next = MODE_NORMAL;
        end else begin
          held_next = ch;
          mode_next = MODE_HEX1;
        end
      end
      MODE_HEX1: begin
        if (closing || hex_good) mode_next = MODE_NORMAL;
        else mode_next = MODE_DROP;
      end
      MODE_DROP: begin
        if (closing) mode_next = MODE_NORMAL;
      end
      default: begin
        if (closing) mode_next = MODE_NORMAL;
        else if (ch == CH_NEWLINE) mode_next = MODE_DROP;
        else if (ch == CH_BACKSLASH) mode_next = MODE_ESC;
        else mode_next = MODE_NORMAL;
      end
    endcase
  end

  // Results for the current item
  always_comb begin
    dec.first  = res_make(KIND_DATA, 8'h00, 8'h00, 8'h00, 2'd0);
    dec.second = res_make(KIND_END, 8'h00, 8'h00, 8'h00, 2'd0);
    dec.count  = 2'd0;
    unique case (mode)
      MODE_ESC: begin
        if (esc_known(ch)) begin
          dec.first = res_make(KIND_DATA, esc_byte(ch), 8'h00, 8'h00, 2'd0);
          dec.count = closing ? 2'd2 : 2'd1;
        end else if (!(ch == CH_X && !closing)) begin
          dec.first = res_make(KIND_BADESC, 8'h00, ch, 8'h00, 2'd0);
          dec.count = 2'd1;
        end
      end
      MODE_HEX0: begin
        if (closing) begin
          dec.first = res_make(KIND_BADHEX, 8'h00, 8'h00, 8'h00, 2'd0);
          dec.count = 2'd1;
        end
      end
      MODE_HEX1: begin
        if (closing) dec.first = res_make(KIND_BADHEX, 8'h00, held, 8'h00, 2'd1);
        else if (hex_good) dec.first = res_make(KIND_DATA, hex_pair, 8'h00, 8'h00, 2'd0);
        else dec.first = res_make(KIND_BADHEX, 8'h00, held, ch, 2'd2);
        dec.count = 2'd1;
      end
      MODE_DROP: begin
        dec.count = 2'd0;
      end
      default: begin
        if (closing) dec.first = res_make(KIND_END, 8'h00, 8'h00, 8'h00, 2'd0);
        else if (ch == CH_NEWLINE) dec.first = res_make(KIND_OPEN, 8'h00, 8'h00, 8'h00, 2'd0);
        else dec.first = res_make(KIND_DATA, ch, 8'h00, 8'h00, 2'd0);
        dec.count = (!closing && ch == CH_BACKSLASH) ? 2'd0 : 2'd1;
      end
    endcase
    dec.first.run_last  = (dec.count == 2'd1);
    dec.second.run_last = 1'b1;
  end

  // Mode and held digit registers, updated when an item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      held <= 8'h00;
    end else if (fire) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

FILE: sv/slu_out_buf.sv
module slu_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slu_pkg::dec_out_t dec,
  output logic              free,
  output logic              result_valid,
  input  logic              result_stall,
  output slu_pkg::res_t     result
);
  import slu_pkg::*;

  logic occupied;
  logic on_second;
  logic has_two;
  res_t slot0;
  res_t slot1;
  logic pop;
  logic last_pop;

  assign result_valid = occupied;
  assign result       = on_second ? slot1 : slot0;
  assign pop          = occupied && !result_stall;
  assign last_pop     = pop && (on_second || !has_two);
  assign free         = !occupied || last_pop;

  // Control: load a new pair or step through the held one
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied  <= 1'b0;
      on_second <= 1'b0;
      has_two   <= 1'b0;
    end else if (push) begin
      occupied  <= 1'b1;
      on_second <= 1'b0;
      has_two   <= (dec.count == 2'd2);
    end else if (last_pop) begin
      occupied  <= 1'b0;
      on_second <= 1'b0;
    end else if (pop) begin
      on_second <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= dec.first;
      slot1 <= dec.second;
    end
  end

endmodule

FILE: sv/string_literal_unescape_top.sv
// String literal unescape decoder.
// Input channel (item_valid / item_stall / item): one raw character of a quoted
// string body per beat; the closing quote comes as a beat with is_closing set.
// Output channel (result_valid / result_stall / result): decoded bytes, the
// end-of-string mark, and error reports; run_last marks the final result of
// the input beat that caused it. A beat yields zero, one or two results.
// A beat in the input register is decoded combinationally and lands in the
// output register once that is free, visible to the receiver then.
// Throughput: one beat per cycle while each beat yields at most one result
// and the receiver does not stall; a beat with two results holds the output
// register until both are taken; beats that yield nothing push no result.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// normal mode. When the receiver stalls, the output register holds its
// result; one more beat waits in the input register, then item_stall rises.
`include "string_literal_unescape_top_macros.svh"

module string_literal_unescape_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  slu_pkg::item_t item,
  output logic           result_valid,
  input  logic           result_stall,
  output slu_pkg::res_t  result
);
  import slu_pkg::*;

  logic     in_full;
  item_t    in_item;
  dec_out_t dec;
  logic     buf_free;
  logic     advance;
  logic     push;

  // Consume the held beat when its results fit in the output register
  assign advance    = in_full && ((dec.count == 2'd0) || buf_free);
  assign push       = advance && (dec.count != 2'd0);
  assign item_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  slu_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .item (in_item),
    .fire (advance),
    .dec  (dec)
  );

  slu_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .dec          (dec),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Checks
  `SLU_ASSERT_NOW(a_first_of_two_is_data, result_valid && !result.run_last,
    result.kind == KIND_DATA, "non-final result is not a data byte")
  `SLU_ASSERT_NOW(a_count_only_hex, result_valid && result.kind != KIND_BADHEX,
    result.detail_count == 2'd0, "detail count set outside hex error")
  `SLU_ASSERT_NOW(a_stall_needs_output, item_stall,
    result_valid, "input stalled while output register is empty")
  `SLU_ASSERT_NEXT(a_push_shows, push,
    result_valid, "loaded result not presented")

endmodule

FILE: tb/string_literal_unescape_top_tb.sv
module string_literal_unescape_top_tb;
  import slu_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  item_t item = '0;
  logic  result_valid;
  logic  result_stall = 1'b0;
  res_t  result;

  string_literal_unescape_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t chars_q[$];
  res_t  decoded_q[$];
  int    n_sent = 0;
  int    n_taken = 0;
  int    n_errors = 0;
  logic  calm;

  // decoder state as the testbench sees it
  mode_t      dec_mode = MODE_NORMAL;
  logic [7:0] held_digit = 8'h00;

  // no idling on either side for a stretch in the middle of the run
  assign calm = (n_taken >= 700) && (n_taken < 1100);

  // single-character escapes; returns 1 when ch names one
  function automatic logic simple_escape(input logic [7:0] ch, output logic [7:0] val);
    val = 8'h00;
    case (ch)
      CH_N:         val = 8'h0A;
      CH_T:         val = 8'h09;
      CH_R:         val = 8'h0D;
      CH_ZERO:      val = 8'h00;
      CH_QUOTE:     val = 8'h22;
      CH_BACKSLASH: val = 8'h5C;
      default:      return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic hex_digit(input logic [7:0] ch, output logic [3:0] nib);
    logic [7:0] d;
    d = 8'h00;
    nib = 4'h0;
    if (ch >= "0" && ch <= "9") d = ch - "0";
    else if (ch >= "a" && ch <= "f") d = ch - "a" + 8'd10;
    else if (ch >= "A" && ch <= "F") d = ch - "A" + 8'd10;
    else return 1'b0;
    nib = d[3:0];
    return 1'b1;
  endfunction

  // work out the results of one accepted beat and queue them
  task automatic decode_char(input item_t it);
    res_t       outs[2];
    int         n;
    logic [7:0] ch;
    logic [7:0] val;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       ok_hi;
    logic       ok_lo;
    n = 0;
    ch = it.char_in;
    outs[0] = '0;
    outs[1] = '0;
    case (dec_mode)
      MODE_ESC: begin
        if (simple_escape(ch, val)) begin
          outs[n].kind = KIND_DATA;
          outs[n].byte_out = val;
          n++;
          if (it.is_closing) begin
            outs[n].kind = KIND_END;
            n++;
          end
          dec_mode = MODE_NORMAL;
        end else if (ch == CH_X && !it.is_closing) begin
          dec_mode = MODE_HEX0;
        end else begin
          outs[n].kind = KIND_BADESC;
          outs[n].detail_first = ch;
          n++;
          dec_mode = it.is_closing ? MODE_NORMAL : MODE_DROP;
        end
      end
      MODE_HEX0: begin
        if (it.is_closing) begin
          outs[n].kind = KIND_BADHEX;
          n++;
          dec_mode = MODE_NORMAL;
        end else begin
          held_digit = ch;
          dec_mode = MODE_HEX1;
        end
      end
      MODE_HEX1: begin
        ok_hi = hex_digit(held_digit, hi);
        ok_lo = hex_digit(ch, lo);
        if (it.is_closing) begin
          outs[n].kind = KIND_BADHEX;
          outs[n].detail_first = held_digit;
          outs[n].detail_count = 2'd1;
          n++;
          dec_mode = MODE_NORMAL;
        end else if (ok_hi && ok_lo && {hi, lo} <= HEX_MAX) begin
          outs[n].kind = KIND_DATA;
          outs[n].byte_out = {hi, lo};
          n++;
          dec_mode = MODE_NORMAL;
        end else begin
          outs[n].kind = KIND_BADHEX;
          outs[n].detail_first = held_digit;
          outs[n].detail_second = ch;
          outs[n].detail_count = 2'd2;
          n++;
          dec_mode = MODE_DROP;
        end
      end
      MODE_DROP: begin
        if (it.is_closing) dec_mode = MODE_NORMAL;
      end
      default: begin
        if (it.is_closing) begin
          outs[n].kind = KIND_END;
          n++;
          dec_mode = MODE_NORMAL;
        end else if (ch == CH_NEWLINE) begin
          outs[n].kind = KIND_OPEN;
          n++;
          dec_mode = MODE_DROP;
        end else if (ch == CH_BACKSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          outs[n].kind = KIND_DATA;
          outs[n].byte_out = ch;
          n++;
          dec_mode = MODE_NORMAL;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      outs[i].run_last = (i == n - 1);
      decoded_q.push_back(outs[i]);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      n_errors++;
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (decoded_q.size() == 0) begin
      $error("result beat with nothing expected: %p", got);
      n_errors++;
    end else begin
      want = decoded_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("byte_out", 32'(want.byte_out), 32'(got.byte_out));
      check_field("detail_first", 32'(want.detail_first), 32'(got.detail_first));
      check_field("detail_second", 32'(want.detail_second), 32'(got.detail_second));
      check_field("detail_count", 32'(want.detail_count), 32'(got.detail_count));
      check_field("run_last", 32'(want.run_last), 32'(got.run_last));
    end
  endtask

  // input driver: presents queued characters, holds them while stalled
  always @(posedge clk) begin
    logic take;
    if (rst) begin
      item_valid <= 1'b0;
      dec_mode = MODE_NORMAL;
      held_digit = 8'h00;
    end else begin
      take = item_valid && !item_stall;
      if (take) begin
        decode_char(item);
        n_taken++;
      end
      if (!item_valid || take) begin
        if (chars_q.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
          item <= chars_q.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      result_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  task automatic add(input logic [7:0] ch, input logic closing);
    item_t it;
    it.char_in = ch;
    it.is_closing = closing;
    chars_q.push_back(it);
    n_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return "0" + nib;
    return (upper ? "A" : "a") + nib - 8'd10;
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(5))
      0: return CH_N;
      1: return CH_T;
      2: return CH_R;
      3: return CH_ZERO;
      4: return CH_QUOTE;
      default: return CH_BACKSLASH;
    endcase
  endfunction

  // one literal of random content, well formed most of the time
  task automatic add_literal();
    int         ntok;
    int         sel;
    logic [7:0] ch;
    logic [7:0] hv;
    ntok = $urandom_range(10);
    for (int t = 0; t < ntok; t++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        ch = 8'($urandom_range(255));
        if (ch == CH_BACKSLASH || ch == CH_NEWLINE) ch = ch ^ 8'h80;
        add(ch, 1'b0);
      end else if (sel < 60) begin
        add(CH_BACKSLASH, 1'b0);
        add(pick_escape(), 1'b0);
      end else if (sel < 75) begin
        hv = 8'($urandom_range(127));
        add(CH_BACKSLASH, 1'b0);
        add(CH_X, 1'b0);
        add(hex_char(hv[7:4], 1'($urandom_range(1))), 1'b0);
        add(hex_char(hv[3:0], 1'($urandom_range(1))), 1'b0);
      end else if (sel < 82) begin
        // bad pair: either out of range or random characters
        add(CH_BACKSLASH, 1'b0);
        add(CH_X, 1'b0);
        if ($urandom_range(1)) begin
          hv = 8'($urandom_range(255, 128));
          add(hex_char(hv[7:4], 1'($urandom_range(1))), 1'b0);
          add(hex_char(hv[3:0], 1'($urandom_range(1))), 1'b0);
        end else begin
          add(8'($urandom_range(255)), 1'b0);
          add(8'($urandom_range(255)), 1'b0);
        end
      end else if (sel < 88) begin
        add(CH_BACKSLASH, 1'b0);
        add(8'($urandom_range(255)), 1'b0);
      end else if (sel < 92) begin
        add(CH_NEWLINE, 1'b0);
      end else begin
        repeat ($urandom_range(2, 1)) add(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
    // ending: plain close, or close inside an unfinished escape
    sel = $urandom_range(99);
    if (sel < 70) begin
      add(8'($urandom_range(255)), 1'b1);
    end else if (sel < 80) begin
      add(CH_BACKSLASH, 1'b0);
      if ($urandom_range(1)) add($urandom_range(1) ? CH_X : pick_escape(), 1'b1);
      else add(8'($urandom_range(255)), 1'b1);
    end else if (sel < 90) begin
      add(CH_BACKSLASH, 1'b0);
      add(CH_X, 1'b0);
      add(8'($urandom_range(255)), 1'b1);
    end else begin
      add(CH_BACKSLASH, 1'b0);
      add(CH_X, 1'b0);
      add(8'($urandom_range(255)), 1'b0);
      add(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    int wait_cyc;
    // extremes of plain data
    add(8'h00, 1'b0);
    add(8'hFF, 1'b0);
    // known escape, largest hex value
    add(CH_BACKSLASH, 1'b0);
    add(CH_N, 1'b0);
    add(CH_BACKSLASH, 1'b0);
    add(CH_X, 1'b0);
    add("7", 1'b0);
    add("F", 1'b0);
    // hex value out of range, then dropping until the close
    add(CH_BACKSLASH, 1'b0);
    add(CH_X, 1'b0);
    add("8", 1'b0);
    add("0", 1'b0);
    add("z", 1'b0);
    add(CH_QUOTE, 1'b1);
    // close right after a backslash: known escape, then x
    add(CH_BACKSLASH, 1'b0);
    add(CH_QUOTE, 1'b1);
    add(CH_BACKSLASH, 1'b0);
    add(CH_X, 1'b1);
    // close after \x, and after \x plus one character
    add(CH_BACKSLASH, 1'b0);
    add(CH_X, 1'b0);
    add(8'h00, 1'b1);
    add(CH_BACKSLASH, 1'b0);
    add(CH_X, 1'b0);
    add("a", 1'b0);
    add(CH_QUOTE, 1'b1);
    // raw newline, then newline inside an escape, closing char ignored
    add(CH_NEWLINE, 1'b0);
    add(CH_QUOTE, 1'b1);
    add(CH_BACKSLASH, 1'b0);
    add(CH_NEWLINE, 1'b0);
    add(8'hFF, 1'b1);
    add(8'hFF, 1'b1);

    while (n_sent < 1850) add_literal();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (n_taken != n_sent) @(posedge clk);
    wait_cyc = 0;
    while (decoded_q.size() != 0 && wait_cyc < 5000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d results never arrived", decoded_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/slu_pkg.sv
sv/slu_decode.sv
sv/slu_out_buf.sv
sv/string_literal_unescape_top.sv
tb/string_literal_unescape_top_tb.sv
